// ===== src/vkt_pkg.sv =====
`timescale 1ns / 1ps
// vkt_pkg: shared types and constants of the velocity key tracker
// depends on nothing
package vkt_pkg;

    localparam logic       KIND_SAMPLE   = 1'b0;
    localparam logic       KIND_DISPATCH = 1'b1;
    localparam logic       EV_UP         = 1'b0;
    localparam logic       EV_DOWN       = 1'b1;
    localparam logic [1:0] LVL_OPEN      = 2'd0;
    localparam logic [1:0] LVL_FIRST     = 2'd1;
    localparam logic [1:0] LVL_BOTH      = 2'd2;
    localparam logic [6:0] VEL_MAX       = 7'd127;
    localparam logic [4:0] MAX_OUT       = 5'd16;
    localparam logic [15:0] SCALE_RST    = 16'd1000;
    localparam logic [7:0]  DELAY_RST    = 8'd10;
    localparam logic        REG_SCALE    = 1'b0;
    localparam logic        REG_DELAY    = 1'b1;

    typedef enum logic [1:0] {
        PH_OPEN      = 2'd0,
        PH_PRESSED   = 2'd1,
        PH_SUSTAINED = 2'd2
    } t_phase;

    typedef struct packed {
        logic        kind;
        logic [5:0]  key;
        logic [1:0]  level;
        logic        pedal_down;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic       event_res;
        logic [5:0] event_key;
        logic [6:0] velocity;
        logic       last;
    } t_out_item;

    // classified command between front and back
    typedef struct packed {
        logic        dispatch;
        logic [5:0]  key;
        logic [1:0]  level;
        logic        pedal;
        logic [31:0] now;
    } t_cmd;

    typedef struct packed {
        logic        valid;
        t_cmd        cmd;
    } t_cmd_if;

    typedef struct packed {
        logic [1:0]  level;
        t_phase      phase;
        logic [31:0] start;
    } t_key_rec;

    typedef struct packed {
        logic [5:0]  key;
        logic [6:0]  vel;
        logic [31:0] due;
    } t_pend;

endpackage

// ===== src/vkt_ram.sv =====
`timescale 1ns / 1ps
// vkt_ram: generic single write, single read ram with registered read data
// depends on nothing
module vkt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/vkt_div.sv =====
`timescale 1ns / 1ps
// vkt_div: 16 bit by 32 bit restoring divider, one quotient bit per cycle
// depends on vkt_pkg
module vkt_div
    import vkt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [15:0] o_quot
);
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [3:0]  r_cnt, n_cnt;
    logic [31:0] r_rem, n_rem;
    logic [15:0] r_num, n_num;
    logic [15:0] r_quot, n_quot;
    logic [31:0] r_den, n_den;
    logic [32:0] rem_sh;
    logic        fits;

    always_comb begin
        rem_sh = {r_rem, r_num[15]};
        fits   = rem_sh >= {1'b0, r_den};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_num  = r_num;
        n_quot = r_quot;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_num  = i_num;
            n_den  = i_den;
            n_quot = '0;
        end else if (r_busy) begin
            n_rem  = fits ? 32'(rem_sh - {1'b0, r_den}) : rem_sh[31:0];
            n_quot = {r_quot[14:0], fits};
            n_num  = {r_num[14:0], 1'b0};
            n_cnt  = r_cnt + 4'd1;
            if (r_cnt == 4'd15) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem  <= n_rem;
        r_num  <= n_num;
        r_quot <= n_quot;
        r_den  <= n_den;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

// ===== src/vkt_front.sv =====
`timescale 1ns / 1ps
// vkt_front: accepts words, drops out-of-range keys, folds level three,
// and holds commands in a two-entry queue; depends on vkt_pkg
module vkt_front
    import vkt_pkg::*;
#(
    parameter int KEY_COUNT = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_in_item i_item,
    output logic     o_busy,
    output t_cmd_if  o_head,
    input  logic     i_pop
);
    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       accept, keep, push;
    t_cmd       cmd;

    always_comb begin
        cmd.dispatch = (i_item.kind == KIND_DISPATCH);
        cmd.key      = i_item.key;
        cmd.level    = (i_item.level == 2'd3) ? LVL_BOTH : i_item.level;
        cmd.pedal    = i_item.pedal_down;
        cmd.now      = i_item.now_ms;
        accept = i_start && !o_busy;
        keep   = cmd.dispatch || (32'(i_item.key) < 32'(KEY_COUNT));
        push   = accept && keep;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
        if (push) begin
            r_mem[r_wp] <= cmd;
        end
    end

    assign o_busy       = (r_cnt == 2'd2);
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.cmd   = r_mem[r_rp];
endmodule

// ===== src/vkt_back.sv =====
`timescale 1ns / 1ps
// vkt_back: sequencer for key state updates, velocity and the pending queue
// depends on vkt_pkg, vkt_ram, vkt_div
module vkt_back
    import vkt_pkg::*;
#(
    parameter int KEY_COUNT   = 64,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd_if     i_head,
    output logic        o_pop,
    input  logic [15:0] i_scale,
    input  logic [7:0]  i_delay,
    output logic        o_valid,
    output t_out_item   o_result
);
    localparam int KAW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int KRW = $bits(t_key_rec);
    localparam int PW  = $bits(t_pend);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_KRD   = 6'b000010,
        S_DIV   = 6'b000100,
        S_ENQ   = 6'b001000,
        S_QSCAN = 6'b010000,
        S_QEND  = 6'b100000
    } t_state;

    t_state              r_state;
    t_cmd                r_cmd;
    logic [KEY_COUNT-1:0] r_kvalid;
    logic [CW-1:0]       r_count, r_i, r_w;
    logic [4:0]          r_n;
    logic                r_hold_v;
    t_pend               r_hold;
    logic [6:0]          r_vel;
    logic [31:0]         r_due;
    logic                r_out_v;
    t_out_item           r_out;

    logic [KAW-1:0]      k_raddr, r_kaddr;
    logic [KRW-1:0]      k_rdata;
    logic                k_we;
    t_key_rec            k_wrec, rec;
    logic [QAW-1:0]      q_raddr, q_waddr;
    logic [PW-1:0]       q_rdata;
    logic                q_we;
    t_pend               q_wdata, ent;

    logic [31:0] travel, new_start;
    logic        strike, keyup, emit, scan_end, div_go, div_done;
    t_phase      new_phase;
    logic [15:0] quot;

    vkt_ram #(.WIDTH(KRW), .DEPTH(KEY_COUNT)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (k_we),
        .i_waddr (r_kaddr),
        .i_wdata (k_wrec),
        .i_raddr (k_raddr),
        .o_rdata (k_rdata)
    );

    vkt_ram #(.WIDTH(PW), .DEPTH(QUEUE_DEPTH)) u_pend_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

    vkt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_go),
        .i_num   (i_scale),
        .i_den   (travel),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    always_comb begin
        // an untouched key reads as open with an invalid start
        rec     = r_kvalid[r_kaddr] ? t_key_rec'(k_rdata) : '0;
        travel  = r_cmd.now - rec.start;
        strike  = (r_cmd.level == LVL_BOTH) && (rec.level != LVL_BOTH);
        new_start = rec.start;
        if (r_cmd.level == LVL_OPEN) begin
            new_start = '0;
        end else if (r_cmd.level == LVL_FIRST && rec.level == LVL_OPEN) begin
            new_start = r_cmd.now;
        end
        new_phase = rec.phase;
        keyup     = strike && r_cmd.pedal;
        if (strike) begin
            new_phase = PH_PRESSED;
        end
        if (r_cmd.level == LVL_OPEN) begin
            if (r_cmd.pedal && rec.phase == PH_PRESSED) begin
                new_phase = PH_SUSTAINED;
            end
            if (!r_cmd.pedal && rec.phase != PH_OPEN) begin
                new_phase = PH_OPEN;
                keyup     = 1'b1;
            end
        end
        k_wrec.level = r_cmd.level;
        k_wrec.phase = new_phase;
        k_wrec.start = new_start;
        k_we    = (r_state == S_KRD);
        k_raddr = KAW'(i_head.cmd.key);
        div_go  = (r_state == S_KRD) && strike && rec.start != '0 && travel != '0;

        ent      = t_pend'(q_rdata);
        emit     = (r_n < MAX_OUT) && (ent.due <= r_cmd.now);
        scan_end = (CW'(r_i + CW'(1)) == r_count);
        q_raddr  = (r_state == S_QSCAN) ? QAW'(r_i + CW'(1)) : '0;
        q_we     = 1'b0;
        q_waddr  = QAW'(r_count);
        q_wdata.key = r_cmd.key;
        q_wdata.vel = r_vel;
        q_wdata.due = r_due;
        if (r_state == S_ENQ) begin
            q_we = (32'(r_count) < 32'(QUEUE_DEPTH));
        end else if (r_state == S_QSCAN && !emit) begin
            q_we    = 1'b1;
            q_waddr = QAW'(r_w);
            q_wdata = ent;
        end
        o_pop = (r_state == S_IDLE) && i_head.valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_kvalid <= '0;
            r_count  <= '0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_out_v <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_head.valid) begin
                        r_cmd   <= i_head.cmd;
                        r_kaddr <= KAW'(i_head.cmd.key);
                        r_i     <= '0;
                        r_w     <= '0;
                        r_n     <= '0;
                        if (!i_head.cmd.dispatch) begin
                            r_state <= S_KRD;
                        end else if (r_count != '0) begin
                            r_state <= S_QSCAN;
                        end
                    end
                end
                S_KRD: begin
                    r_kvalid[r_kaddr] <= 1'b1;
                    r_due <= r_cmd.now + (r_cmd.pedal ? 32'(i_delay) : 32'd0);
                    r_vel <= VEL_MAX;
                    if (keyup) begin
                        r_out_v <= 1'b1;
                        r_out   <= '{event_res: EV_UP, event_key: r_cmd.key,
                                     velocity: 7'd0, last: 1'b1};
                    end
                    if (!strike) begin
                        r_state <= S_IDLE;
                    end else if (div_go) begin
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_ENQ;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_vel   <= (quot > 16'(VEL_MAX)) ? VEL_MAX : quot[6:0];
                        r_state <= S_ENQ;
                    end
                end
                S_ENQ: begin
                    if (q_we) begin
                        r_count <= r_count + CW'(1);
                    end
                    r_state <= S_IDLE;
                end
                S_QSCAN: begin
                    if (emit) begin
                        // hold one key-down back so the final one can carry last
                        if (r_hold_v) begin
                            r_out_v <= 1'b1;
                            r_out   <= '{event_res: EV_DOWN, event_key: r_hold.key,
                                         velocity: r_hold.vel, last: 1'b0};
                        end
                        r_hold   <= ent;
                        r_hold_v <= 1'b1;
                        r_n      <= r_n + 5'd1;
                    end else begin
                        r_w <= r_w + CW'(1);
                    end
                    if (scan_end) begin
                        r_state <= S_QEND;
                    end else begin
                        r_i <= r_i + CW'(1);
                    end
                end
                S_QEND: begin
                    r_count <= r_w;
                    if (r_hold_v) begin
                        r_out_v <= 1'b1;
                        r_out   <= '{event_res: EV_DOWN, event_key: r_hold.key,
                                     velocity: r_hold.vel, last: 1'b1};
                    end
                    r_hold_v <= 1'b0;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid  = r_out_v;
    assign o_result = r_out;
endmodule

// ===== src/velocity_key_tracker.sv =====
`timescale 1ns / 1ps
// velocity_key_tracker: a key sample passes the back end through S_IDLE and S_KRD; a
// strike goes on to S_ENQ, through S_DIV when it runs the divider; any key-up is registered
// in S_KRD. a dispatch ends in S_IDLE when the pending queue is empty, else S_QSCAN walks
// the queue and S_QEND sends the last key-down. a two-word command queue lets
// start be taken while the back end works. results appear one cycle each with
// o_valid and cannot be stalled. synchronous active-low reset clears key state and queue.
module velocity_key_tracker
    import vkt_pkg::*;
#(
    parameter int KEY_COUNT   = 64,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  t_in_item    i_item,
    output logic        busy,
    output logic        o_valid,
    output t_out_item   o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [15:0] r_scale;
    logic [7:0]  r_delay;
    t_cmd_if     head;
    logic        pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RST;
            r_delay <= DELAY_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_SCALE: r_scale <= pwdata[15:0];
                REG_DELAY: r_delay <= pwdata[7:0];
                default:   r_scale <= r_scale;
            endcase
        end
    end

    assign prdata = (paddr[2] == REG_DELAY) ? 32'(r_delay) : 32'(r_scale);
    assign pready = 1'b1;

    vkt_front #(.KEY_COUNT(KEY_COUNT)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (i_item),
        .o_busy  (busy),
        .o_head  (head),
        .i_pop   (pop)
    );

    vkt_back #(.KEY_COUNT(KEY_COUNT), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .o_pop    (pop),
        .i_scale  (r_scale),
        .i_delay  (r_delay),
        .o_valid  (o_valid),
        .o_result (o_result)
    );
endmodule

// ===== tb/velocity_key_tracker_test.sv =====
`timescale 1ns / 1ps
// velocity_key_tracker_test: self-checking bench for the velocity key tracker
// depends on vkt_pkg and velocity_key_tracker; predicts key events per word
module velocity_key_tracker_test;
    import vkt_pkg::*;

    localparam int NKEYS       = 64;
    localparam int QSLOTS      = 16;
    localparam int DRAIN_WAIT  = 100;
    localparam int STALL_LIMIT = 20000;
    localparam logic [2:0] ADDR_SCALE = 3'd0;
    localparam logic [2:0] ADDR_DELAY = 3'd4;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    t_in_item    i_item = '0;
    logic        busy;
    logic        o_valid;
    t_out_item   o_result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    velocity_key_tracker DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_item(i_item),
        .busy(busy), .o_valid(o_valid), .o_result(o_result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    // predicted key tracker state
    logic [15:0] scale_reg = SCALE_RST;
    logic [7:0]  delay_reg = DELAY_RST;
    logic [1:0]  key_level [NKEYS];
    t_phase      key_ph [NKEYS];
    logic [31:0] press_time [NKEYS];
    t_pend       strike_q [$];

    t_in_item    word_q [$];
    t_out_item   event_q [$];
    int          mismatches = 0;
    int          stall_cycles = 0;
    bit          no_idle = 1'b0;
    logic [31:0] clock_ms = 32'd1;

    initial begin
        for (int k = 0; k < NKEYS; k++) begin
            key_level[k] = LVL_OPEN;
            key_ph[k] = PH_OPEN;
            press_time[k] = '0;
        end
    end

    function automatic logic [6:0] strike_speed(logic [31:0] t0, logic [31:0] t1);
        logic [31:0] travel;
        logic [31:0] q;
        travel = t1 - t0;
        if (t0 == 0 || travel == 0) return VEL_MAX;
        q = 32'(scale_reg) / travel;
        return (q > 127) ? VEL_MAX : q[6:0];
    endfunction

    task automatic push_event(logic res, logic [5:0] k, logic [6:0] v);
        t_out_item e;
        e.event_res = res;
        e.event_key = k;
        e.velocity = v;
        e.last = 1'b0;
        event_q = {event_q, e};
    endtask

    task automatic predict_events(t_in_item it);
        int          produced;
        logic [1:0]  lvl;
        logic [6:0]  v;
        t_pend       p;
        t_pend       kept [$];
        produced = 0;
        if (it.kind == KIND_DISPATCH) begin
            foreach (strike_q[i]) begin
                if (produced < 16 && strike_q[i].due <= it.now_ms) begin
                    push_event(EV_DOWN, strike_q[i].key, strike_q[i].vel);
                    produced++;
                end else begin
                    kept = {kept, strike_q[i]};
                end
            end
            strike_q = kept;
        end else begin
            lvl = (it.level == 2'd3) ? LVL_BOTH : it.level;
            if (lvl == LVL_OPEN) press_time[it.key] = '0;
            if (lvl == LVL_FIRST && key_level[it.key] == LVL_OPEN)
                press_time[it.key] = it.now_ms;
            if (lvl == LVL_BOTH && key_level[it.key] != LVL_BOTH) begin
                v = strike_speed(press_time[it.key], it.now_ms);
                p.key = it.key;
                p.vel = v;
                p.due = it.now_ms;
                if (it.pedal_down) begin
                    push_event(EV_UP, it.key, 7'd0);
                    produced++;
                    p.due = it.now_ms + 32'(delay_reg);
                end
                if (strike_q.size() < QSLOTS) strike_q = {strike_q, p};
                key_ph[it.key] = PH_PRESSED;
            end
            if (lvl == LVL_OPEN) begin
                if (it.pedal_down && key_ph[it.key] == PH_PRESSED)
                    key_ph[it.key] = PH_SUSTAINED;
                if (!it.pedal_down && key_ph[it.key] != PH_OPEN) begin
                    key_ph[it.key] = PH_OPEN;
                    push_event(EV_UP, it.key, 7'd0);
                    produced++;
                end
            end
            key_level[it.key] = lvl;
        end
        if (produced > 0) event_q[event_q.size() - 1].last = 1'b1;
    endtask

    // driver: one word in flight, held until taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!(start && busy)) begin
            if (start) predict_events(i_item);
            if (word_q.size() > 0 && (no_idle || $urandom_range(99) >= 17)) begin
                i_item <= word_q.pop_front();
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid) begin
            if (event_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: %p", o_result);
            end else begin
                want = event_q.pop_front();
                if (o_result.event_res !== want.event_res
                        || o_result.event_key !== want.event_key
                        || o_result.velocity !== want.velocity
                        || o_result.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, o_result);
                end
            end
        end
    end

    // watchdog on handshake progress
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic t_in_item mk(logic kd, logic [5:0] k, logic [1:0] lv, logic pd,
                                    logic [31:0] t);
        t_in_item it;
        it.kind = kd;
        it.key = k;
        it.level = lv;
        it.pedal_down = pd;
        it.now_ms = t;
        return it;
    endfunction

    task automatic queue_word(t_in_item it);
        word_q = {word_q, it};
    endtask

    task automatic drain();
        while (word_q.size() > 0 || start || event_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [2:0] addr, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_SCALE) scale_reg = val[15:0];
        else delay_reg = val[7:0];
    endtask

    task automatic fill_random(int count);
        int made;
        int r;
        logic [5:0] k;
        made = 0;
        while (made < count) begin
            r = $urandom_range(99);
            if (r < 15) begin
                queue_word(t_in_item'({$urandom, $urandom}));
                made++;
            end else if (r < 30) begin
                queue_word(mk(KIND_DISPATCH, 6'($urandom), 2'($urandom),
                              1'($urandom), clock_ms + $urandom_range(0, 300)));
                made++;
            end else if (r < 34) begin
                // strike burst to push the pending queue past full
                repeat (18) begin
                    queue_word(mk(KIND_SAMPLE, 6'($urandom), LVL_OPEN, 1'b0, clock_ms));
                    queue_word(mk(KIND_SAMPLE, word_q[$].key, LVL_BOTH,
                                  1'($urandom), clock_ms + 1));
                end
                made += 36;
            end else begin
                k = 6'($urandom);
                clock_ms += $urandom_range(1, 50);
                queue_word(mk(KIND_SAMPLE, k, LVL_FIRST, 1'($urandom), clock_ms));
                clock_ms += ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 400);
                queue_word(mk(KIND_SAMPLE, k, ($urandom_range(3) == 0) ? 2'd3 : LVL_BOTH,
                              1'($urandom), clock_ms));
                if ($urandom_range(4) == 0)
                    queue_word(mk(KIND_SAMPLE, k, LVL_BOTH, 1'($urandom), clock_ms));
                clock_ms += $urandom_range(0, 200);
                queue_word(mk(KIND_SAMPLE, k, LVL_OPEN, 1'($urandom), clock_ms));
                if ($urandom_range(2) == 0)
                    queue_word(mk(KIND_SAMPLE, k, LVL_OPEN, 1'b0, clock_ms));
                made += 3;
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings
        queue_word(mk(KIND_SAMPLE, 6'd0, LVL_FIRST, 1'b0, 32'd0));       // start invalid
        queue_word(mk(KIND_SAMPLE, 6'd0, LVL_BOTH, 1'b0, 32'd5));
        queue_word(mk(KIND_SAMPLE, 6'd63, LVL_FIRST, 1'b0, 32'd100));
        queue_word(mk(KIND_SAMPLE, 6'd63, LVL_BOTH, 1'b0, 32'd100));     // zero travel
        queue_word(mk(KIND_SAMPLE, 6'd5, LVL_FIRST, 1'b0, 32'd5000));
        queue_word(mk(KIND_SAMPLE, 6'd5, LVL_BOTH, 1'b0, 32'd10));       // time ran back
        queue_word(mk(KIND_SAMPLE, 6'd6, LVL_FIRST, 1'b1, 32'd200));
        queue_word(mk(KIND_SAMPLE, 6'd6, 2'd3, 1'b1, 32'd220));          // pedal retrigger
        queue_word(mk(KIND_SAMPLE, 6'd6, LVL_OPEN, 1'b1, 32'd230));      // sustained
        queue_word(mk(KIND_SAMPLE, 6'd6, LVL_OPEN, 1'b0, 32'd240));      // pedal up
        queue_word(mk(KIND_DISPATCH, 6'd0, LVL_OPEN, 1'b0, 32'd225));
        queue_word(mk(KIND_DISPATCH, 6'd63, 2'd3, 1'b1, 32'hFFFF_FFFF));
        queue_word(mk(KIND_SAMPLE, 6'd0, LVL_OPEN, 1'b0, 32'd300));
        queue_word(mk(KIND_SAMPLE, 6'd63, LVL_OPEN, 1'b1, 32'd300));
        queue_word(mk(KIND_SAMPLE, 6'd63, LVL_OPEN, 1'b0, 32'd301));
        queue_word(mk(KIND_SAMPLE, 6'd9, LVL_FIRST, 1'b1, 32'hFFFF_FFF0));
        queue_word(mk(KIND_SAMPLE, 6'd9, LVL_BOTH, 1'b1, 32'hFFFF_FFF8)); // due wraps
        queue_word(mk(KIND_DISPATCH, 6'd0, LVL_OPEN, 1'b0, 32'd3));
        queue_word(mk(KIND_SAMPLE, 6'd5, LVL_OPEN, 1'b0, 32'd400));
        queue_word(mk(KIND_SAMPLE, 6'd9, LVL_OPEN, 1'b0, 32'd400));
        queue_word(mk(KIND_DISPATCH, 6'd0, LVL_OPEN, 1'b0, 32'hFFFF_FFFF));
        drain();

        reg_write(ADDR_SCALE, 32'd1);
        reg_write(ADDR_DELAY, 32'd0);
        fill_random(100);
        drain();

        reg_write(ADDR_SCALE, 32'hFFFF_FFFF);
        reg_write(ADDR_DELAY, 32'hFFFF_FFFF);
        no_idle = 1'b1;
        fill_random(80);
        drain();
        no_idle = 1'b0;

        reg_write(ADDR_SCALE, $urandom_range(100, 20000));
        reg_write(ADDR_DELAY, $urandom_range(1, 60));
        fill_random(100);
        queue_word(mk(KIND_DISPATCH, 6'd0, LVL_OPEN, 1'b0, 32'hFFFF_FFFF));
        queue_word(mk(KIND_DISPATCH, 6'd0, LVL_OPEN, 1'b0, 32'hFFFF_FFFF));
        drain();

        if (mismatches == 0 && event_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== velocity_key_tracker.f =====
src/vkt_pkg.sv
src/vkt_ram.sv
src/vkt_div.sv
src/vkt_front.sv
src/vkt_back.sv
src/velocity_key_tracker.sv
tb/velocity_key_tracker_test.sv
